### rtl/toze_pkg.sv
// Types and constants shared by the zone event block and its divider.
`timescale 1ns / 1ps

package toze_pkg;

    localparam int POS_W      = 12;
    localparam int SHIFT_W    = 13;
    localparam int SLOT_W     = 4;
    localparam int OP_W       = 2;
    localparam int Q_W        = 16;
    localparam int NORM_W     = Q_W + 1;
    localparam int DIFF_W     = POS_W + 3;
    localparam int SPAN_W     = POS_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SHIFT_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_APPEARED,
        OP_MOVED,
        OP_VANISHED,
        OP_UNUSED
    } t_op;

    typedef enum logic [1:0] {
        ST_DEAD,
        ST_IN,
        ST_OUT
    } t_status;

    typedef enum logic [1:0] {
        EV_JOINED,
        EV_MOVED,
        EV_LEFT
    } t_evt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_LEFT,
        CFG_AREA_TOP,
        CFG_AREA_RIGHT,
        CFG_AREA_BOTTOM,
        CFG_SHIFT_X,
        CFG_SHIFT_Y
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        AX_ZERO,
        AX_FULL,
        AX_DIV
    } t_axis;

endpackage

### rtl/toze_div.sv
// Bit-serial restoring divider: Q0.16 quotient of a fraction below one.
`timescale 1ns / 1ps

module toze_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [toze_pkg::POS_W-1:0]  i_dividend,
    input  logic [toze_pkg::POS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [toze_pkg::Q_W-1:0]    o_quot
);

    localparam int CNT_W = $clog2(toze_pkg::Q_W + 1);

    logic [CNT_W-1:0]           r_cnt,  n_cnt;
    logic [toze_pkg::POS_W-1:0] r_rem,  n_rem;
    logic [toze_pkg::POS_W-1:0] r_div,  n_div;
    logic [toze_pkg::Q_W-1:0]   r_quot, n_quot;
    logic                       r_done, n_done;

    logic [toze_pkg::POS_W:0]   w_trial;
    logic [toze_pkg::POS_W:0]   w_diff;
    logic                       w_ge;

    assign w_trial = {r_rem, 1'b0};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = i_dividend;
            n_div = i_divisor;
            n_cnt = CNT_W'(toze_pkg::Q_W);
        end else if (r_cnt != '0) begin
            n_rem  = w_ge ? w_diff[toze_pkg::POS_W-1:0] : w_trial[toze_pkg::POS_W-1:0];
            n_quot = {r_quot[toze_pkg::Q_W-2:0], w_ge};
            n_cnt  = r_cnt - CNT_W'(1);
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef SYNTHESIS
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_cnt == CNT_W'(toze_pkg::Q_W)))
        else $error("divider did not load its step count");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0))
        else $error("divider done while steps remain");
`endif

endmodule

### rtl/tracked_object_zone_events.sv
// Top level: tracked-object events to area joined, moved and left events.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata x,y,slot; tuser opcode
//  m_axis    out        m_axis_tvalid/tready      tdata slot,norm_x,norm_y; tuser code
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
//  After a word is accepted the block offsets and classifies both axes and
//  loads the dividers, runs 16 bit-serial quotient steps (both axes at once),
//  waits for the divider done flag and then decides the event.
//  A new word is taken only while no earlier word is in progress.
//  A word with opcode 3 or an unused slot is dropped on acceptance.
//  Reset is synchronous; it marks every slot dead and loads the default area.
//  A result that waits in the output register holds the block in its last
//  step; the next word is taken once the block is back to idle.

module tracked_object_zone_events #(
    parameter int MAX_SLOTS    = 16,
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] x_pos, [23:12] y_pos, [27:24] slot, [31:28] zero
    input  logic [toze_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] opcode
    input  logic [toze_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] event_slot, [20:4] norm_x, [37:21] norm_y, [39:38] zero
    output logic [toze_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] event_code
    output logic [1:0]                         m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [toze_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [toze_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SLOT_DEPTH = (MAX_SLOTS < 16) ? MAX_SLOTS : 16;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int SLOT_N     = 2 ** SLOT_AW;
    localparam logic [8:0] SLOT_LIMIT = 9'(MAX_SLOTS);
    localparam int PW = toze_pkg::POS_W;
    localparam int DW = toze_pkg::DIFF_W;
    localparam int SW = toze_pkg::SPAN_W;

    // configuration
    logic [PW-1:0]                  r_area_left, r_area_top, r_area_right, r_area_bottom;
    logic [toze_pkg::SHIFT_W-1:0]   r_shift_x, r_shift_y;

    // control and item
    toze_pkg::t_state               r_state, n_state;
    toze_pkg::t_op                  r_op, n_op;
    logic [PW-1:0]                  r_x_pos, n_x_pos, r_y_pos, n_y_pos;
    logic [toze_pkg::SLOT_W-1:0]    r_slot, n_slot;
    toze_pkg::t_axis                r_x_kind, n_x_kind, r_y_kind, n_y_kind;
    logic                           r_x_in, n_x_in, r_y_in, n_y_in;
    toze_pkg::t_status              r_status [SLOT_N];

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [toze_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;
    toze_pkg::t_evt                 r_out_user, n_out_user;

    logic                           w_accept;
    logic                           w_keep;
    logic signed [DW-1:0]           w_dx, w_dy;
    logic signed [SW-1:0]           w_sx, w_sy;
    toze_pkg::t_axis                w_x_kind, w_y_kind;
    logic                           w_x_in, w_y_in;
    logic                           w_div_start;
    logic                           w_done_x, w_done_y;
    logic [toze_pkg::Q_W-1:0]       w_quot_x, w_quot_y;
    logic [toze_pkg::NORM_W-1:0]    w_norm_x, w_norm_y;
    logic [SLOT_AW-1:0]             w_idx;
    toze_pkg::t_status              w_st, w_new_st;
    toze_pkg::t_evt                 w_code;
    logic                           w_emit;
    logic                           w_free;
    logic                           w_load;
    logic                           w_st_we;

    function automatic toze_pkg::t_axis axis_kind(input logic signed [DW-1:0] d,
                                                  input logic signed [SW-1:0] s);
        logic signed [DW-1:0] s_ext;
        s_ext = DW'(s);
        if (s <= 0 || d < 0)
            axis_kind = toze_pkg::AX_ZERO;
        else if (d >= s_ext)
            axis_kind = toze_pkg::AX_FULL;
        else
            axis_kind = toze_pkg::AX_DIV;
    endfunction

    function automatic logic axis_in(input logic signed [DW-1:0] d,
                                     input logic signed [SW-1:0] s);
        logic signed [DW-1:0] s_ext;
        s_ext = DW'(s);
        axis_in = (s > 0) && (d >= 0) && (d <= s_ext);
    endfunction

    function automatic logic [toze_pkg::NORM_W-1:0] axis_norm(input toze_pkg::t_axis k,
            input logic [toze_pkg::Q_W-1:0] q);
        unique case (k)
            toze_pkg::AX_FULL: axis_norm = {1'b1, {toze_pkg::Q_W{1'b0}}};
            toze_pkg::AX_DIV:  axis_norm = {1'b0, q};
            default:           axis_norm = '0;
        endcase
    endfunction

    assign s_axis_tready = (r_state == toze_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_keep        = (s_axis_tuser != toze_pkg::OP_UNUSED)
                        && ({5'b0, s_axis_tdata[27:24]} < SLOT_LIMIT);

    assign w_dx = $signed({3'b0, r_x_pos}) + DW'($signed(r_shift_x))
                - $signed({3'b0, r_area_left});
    assign w_dy = $signed({3'b0, r_y_pos}) + DW'($signed(r_shift_y))
                - $signed({3'b0, r_area_top});
    assign w_sx = $signed({1'b0, r_area_right})  - $signed({1'b0, r_area_left});
    assign w_sy = $signed({1'b0, r_area_bottom}) - $signed({1'b0, r_area_top});

    assign w_x_kind = axis_kind(w_dx, w_sx);
    assign w_y_kind = axis_kind(w_dy, w_sy);
    assign w_x_in   = axis_in(w_dx, w_sx);
    assign w_y_in   = axis_in(w_dy, w_sy);

    assign w_div_start = (r_state == toze_pkg::S_PREP);

    toze_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dx[PW-1:0]),
        .i_divisor  (w_sx[PW-1:0]),
        .o_done     (w_done_x),
        .o_quot     (w_quot_x)
    );

    toze_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dy[PW-1:0]),
        .i_divisor  (w_sy[PW-1:0]),
        .o_done     (w_done_y),
        .o_quot     (w_quot_y)
    );

    assign w_norm_x = axis_norm(r_x_kind, w_quot_x);
    assign w_norm_y = axis_norm(r_y_kind, w_quot_y);
    assign w_idx    = r_slot[SLOT_AW-1:0];
    assign w_st     = r_status[w_idx];
    assign w_free   = !r_out_valid || m_axis_tready;

    // event decision
    always_comb begin
        w_emit   = 1'b0;
        w_code   = toze_pkg::EV_JOINED;
        w_new_st = w_st;
        unique case (r_op)
            toze_pkg::OP_APPEARED: begin
                if (r_x_in && r_y_in) begin
                    w_emit   = 1'b1;
                    w_new_st = toze_pkg::ST_IN;
                end else begin
                    w_new_st = toze_pkg::ST_OUT;
                end
            end
            toze_pkg::OP_MOVED: begin
                if (r_x_in && r_y_in) begin
                    w_emit   = 1'b1;
                    w_code   = (w_st == toze_pkg::ST_IN) ? toze_pkg::EV_MOVED
                                                         : toze_pkg::EV_JOINED;
                    w_new_st = toze_pkg::ST_IN;
                end else begin
                    w_emit   = (w_st == toze_pkg::ST_IN);
                    w_code   = toze_pkg::EV_LEFT;
                    w_new_st = toze_pkg::ST_OUT;
                end
            end
            toze_pkg::OP_VANISHED: begin
                w_emit   = (w_st == toze_pkg::ST_IN);
                w_code   = toze_pkg::EV_LEFT;
                w_new_st = toze_pkg::ST_DEAD;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x_pos     = r_x_pos;
        n_y_pos     = r_y_pos;
        n_slot      = r_slot;
        n_x_kind    = r_x_kind;
        n_y_kind    = r_y_kind;
        n_x_in      = r_x_in;
        n_y_in      = r_y_in;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        w_load      = 1'b0;
        w_st_we     = 1'b0;
        unique case (r_state)
            toze_pkg::S_IDLE: begin
                if (w_accept && w_keep) begin
                    n_op    = toze_pkg::t_op'(s_axis_tuser);
                    n_x_pos = s_axis_tdata[11:0];
                    n_y_pos = s_axis_tdata[23:12];
                    n_slot  = s_axis_tdata[27:24];
                    n_state = toze_pkg::S_PREP;
                end
            end
            toze_pkg::S_PREP: begin
                n_x_kind = w_x_kind;
                n_y_kind = w_y_kind;
                n_x_in   = w_x_in;
                n_y_in   = w_y_in;
                n_state  = toze_pkg::S_DIV;
            end
            toze_pkg::S_DIV: begin
                if (w_done_x && w_done_y) begin
                    n_state = toze_pkg::S_DONE;
                end
            end
            toze_pkg::S_DONE: begin
                if (w_free) begin
                    w_st_we = 1'b1;
                    w_load  = w_emit;
                    n_state = toze_pkg::S_IDLE;
                    if (w_emit) begin
                        n_out_valid = 1'b1;
                        n_out_user  = w_code;
                        n_out_data  = {2'b00, w_norm_y, w_norm_x, r_slot};
                    end
                end
            end
            default: begin
                n_state = toze_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= toze_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_x_pos    <= n_x_pos;
        r_y_pos    <= n_y_pos;
        r_slot     <= n_slot;
        r_x_kind   <= n_x_kind;
        r_y_kind   <= n_y_kind;
        r_x_in     <= n_x_in;
        r_y_in     <= n_y_in;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_N; i++) begin
                r_status[i] <= toze_pkg::ST_DEAD;
            end
        end else if (w_st_we) begin
            r_status[w_idx] <= w_new_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_left   <= PW'(1);
            r_area_top    <= PW'(1);
            r_area_right  <= PW'(FRAME_WIDTH);
            r_area_bottom <= PW'(FRAME_HEIGHT);
            r_shift_x     <= '0;
            r_shift_y     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                toze_pkg::CFG_AREA_LEFT:   r_area_left   <= i_cfg_data[PW-1:0];
                toze_pkg::CFG_AREA_TOP:    r_area_top    <= i_cfg_data[PW-1:0];
                toze_pkg::CFG_AREA_RIGHT:  r_area_right  <= i_cfg_data[PW-1:0];
                toze_pkg::CFG_AREA_BOTTOM: r_area_bottom <= i_cfg_data[PW-1:0];
                toze_pkg::CFG_SHIFT_X:     r_shift_x     <= i_cfg_data;
                toze_pkg::CFG_SHIFT_Y:     r_shift_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || m_axis_tready))
        else $error("result loaded over a word not yet taken");
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_x || w_done_y) |-> (r_state == toze_pkg::S_DIV))
        else $error("divider finished outside the divide step");
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x == w_done_y)
        else $error("axis dividers out of step");
    a_moved_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_code != toze_pkg::EV_LEFT) |=> (r_status[$past(w_idx)] == toze_pkg::ST_IN))
        else $error("joined or moved event without slot marked inside");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for the tracked-object zone event block.
`timescale 1ns / 1ps

module tb;
    import toze_pkg::*;

    localparam int          SLOT_COUNT    = 16;
    localparam int          SETTLE_CYCLES = 30;
    localparam logic [2:0]  CFG_SPARE_A   = 3'd6;
    localparam logic [2:0]  CFG_SPARE_B   = 3'd7;
    localparam logic [16:0] Q_ONE         = 17'h10000;

    typedef struct packed {
        t_evt        code;
        logic [3:0]  slot;
        logic [16:0] nx;
        logic [16:0] ny;
    } zone_event_t;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] x;
        logic [11:0] y;
        logic [3:0]  slot;
        bit          typed;
        bit          typed_has;
        zone_event_t ev;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    logic [11:0]        cfg_left, cfg_top, cfg_right, cfg_bottom;
    logic signed [12:0] cfg_shift_x, cfg_shift_y;
    t_status            slot_state [SLOT_COUNT];

    zone_event_t pending_events [$];
    stim_row_t   dir_rows [$];
    int          fail_count      = 0;
    int          words_sent      = 0;
    int          results_checked = 0;
    int          settings_applied = 0;
    bit          quiet_spell     = 1'b0;

    tracked_object_zone_events dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_spell || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [16:0] scale_axis(input logic [11:0] pos,
                                               input logic signed [12:0] shift,
                                               input logic [11:0] lo,
                                               input logic [11:0] hi,
                                               output bit in_range);
        int p, sh, l, h, d, s;
        p = pos;
        sh = shift;
        l = lo;
        h = hi;
        d = p + sh - l;
        s = h - l;
        in_range = 1'b1;
        if (s <= 0 || d < 0) begin
            in_range = 1'b0;
            return '0;
        end
        if (d > s) begin
            in_range = 1'b0;
            return Q_ONE;
        end
        if (d == s) return Q_ONE;
        return 17'((d * 65536) / s);
    endfunction

    function automatic bit zone_predict(input logic [1:0] op, input logic [11:0] x,
                                        input logic [11:0] y, input logic [3:0] slot,
                                        output zone_event_t ev);
        bit      in_x, in_y, hit;
        t_status was;
        hit = 1'b0;
        ev = '0;
        if (op == OP_UNUSED || int'(slot) >= SLOT_COUNT) return 1'b0;
        ev.nx = scale_axis(x, cfg_shift_x, cfg_left, cfg_right, in_x);
        ev.ny = scale_axis(y, cfg_shift_y, cfg_top, cfg_bottom, in_y);
        ev.slot = slot;
        was = slot_state[slot];
        case (op)
            OP_APPEARED: begin
                if (in_x && in_y) begin
                    hit = 1'b1;
                    ev.code = EV_JOINED;
                    slot_state[slot] = ST_IN;
                end else begin
                    slot_state[slot] = ST_OUT;
                end
            end
            OP_MOVED: begin
                if (in_x && in_y) begin
                    hit = 1'b1;
                    ev.code = (was == ST_IN) ? EV_MOVED : EV_JOINED;
                    slot_state[slot] = ST_IN;
                end else begin
                    if (was == ST_IN) begin
                        hit = 1'b1;
                        ev.code = EV_LEFT;
                    end
                    slot_state[slot] = ST_OUT;
                end
            end
            OP_VANISHED: begin
                if (was == ST_IN) begin
                    hit = 1'b1;
                    ev.code = EV_LEFT;
                end
                slot_state[slot] = ST_DEAD;
            end
            default: ;
        endcase
        return hit;
    endfunction

    function automatic logic [11:0] pick_coord(input logic [11:0] lo, input logic [11:0] hi,
                                               input logic signed [12:0] shift);
        int a, b, sh, v, r;
        a = lo;
        b = hi;
        sh = shift;
        r = $urandom_range(0, 99);
        if (a > b) begin
            v = a;
            a = b;
            b = v;
        end
        if (r < 60) v = int'($urandom_range(a, b)) - sh;
        else if (r < 72) v = ($urandom_range(0, 1) ? a : b) - sh + int'($urandom_range(0, 2)) - 1;
        else v = $urandom_range(0, 4095);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    function automatic stim_row_t tab_row(input logic [1:0] op, input int x, input int y,
                                          input int slot, input bit typed, input bit has,
                                          input t_evt code, input int nx, input int ny);
        stim_row_t row;
        row.op = op;
        row.x = 12'(x);
        row.y = 12'(y);
        row.slot = 4'(slot);
        row.typed = typed;
        row.typed_has = has;
        row.ev.code = code;
        row.ev.slot = 4'(slot);
        row.ev.nx = 17'(nx);
        row.ev.ny = 17'(ny);
        return row;
    endfunction

    task automatic feed_word(input logic [1:0] op, input logic [11:0] x, input logic [11:0] y,
                             input logic [3:0] slot, input bit typed, input bit typed_has,
                             input zone_event_t typed_ev);
        int          gap;
        bit          has;
        zone_event_t ev;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, slot, y, x};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        has = zone_predict(op, x, y, slot, ev);
        if (typed) begin
            has = typed_has;
            ev = typed_ev;
        end
        if (has) pending_events.push_back(ev);
        if (op != OP_UNUSED) words_sent++;
    endtask

    // drop the stream and wait for every pending word, then for the pipeline
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_AREA_LEFT:   cfg_left    = data[11:0];
            CFG_AREA_TOP:    cfg_top     = data[11:0];
            CFG_AREA_RIGHT:  cfg_right   = data[11:0];
            CFG_AREA_BOTTOM: cfg_bottom  = data[11:0];
            CFG_SHIFT_X:     cfg_shift_x = data;
            CFG_SHIFT_Y:     cfg_shift_y = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_area(input int l, input int t, input int r, input int b,
                            input int sx, input int sy);
        cfg_write(CFG_AREA_LEFT,   {1'($urandom_range(0, 1)), 12'(l)});
        cfg_write(CFG_AREA_TOP,    {1'($urandom_range(0, 1)), 12'(t)});
        cfg_write(CFG_AREA_RIGHT,  {1'($urandom_range(0, 1)), 12'(r)});
        cfg_write(CFG_AREA_BOTTOM, {1'($urandom_range(0, 1)), 12'(b)});
        cfg_write(CFG_SHIFT_X, 13'(sx));
        cfg_write(CFG_SHIFT_Y, 13'(sy));
        settings_applied++;
    endtask

    task automatic random_run(input int count);
        int         done, r;
        logic [1:0] op;
        logic [3:0] slot;
        done = 0;
        while (done < count) begin
            slot = 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            if (r < 4) op = OP_UNUSED;
            else if (slot_state[slot] == ST_DEAD)
                op = (r < 80) ? OP_APPEARED : ($urandom_range(0, 1) ? OP_MOVED : OP_VANISHED);
            else if (r < 70) op = OP_MOVED;
            else if (r < 85) op = OP_VANISHED;
            else op = OP_APPEARED;
            if ($urandom_range(0, 99) == 0) settle();
            feed_word(op, pick_coord(cfg_left, cfg_right, cfg_shift_x),
                      pick_coord(cfg_top, cfg_bottom, cfg_shift_y), slot, 1'b0, 1'b0, '0);
            if (op != OP_UNUSED) done++;
        end
        settle();
    endtask

    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            int gap;
            gap = idle_len();
            if (gap == 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        zone_event_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.code = t_evt'(m_axis_tuser);
            got.slot = m_axis_tdata[3:0];
            got.nx   = m_axis_tdata[20:4];
            got.ny   = m_axis_tdata[37:21];
            results_checked++;
            if (pending_events.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected word code %0d slot %0d x %0d y %0d",
                             $realtime, got.code, got.slot, got.nx, got.ny);
            end else begin
                want = pending_events.pop_front();
                if (got.code !== want.code || got.slot !== want.slot ||
                    got.nx !== want.nx || got.ny !== want.ny) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp code %0d slot %0d x %0d y %0d, got code %0d slot %0d x %0d y %0d",
                                 $realtime, want.code, want.slot, want.nx, want.ny,
                                 got.code, got.slot, got.nx, got.ny);
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        cfg_left      = 12'd1;
        cfg_top       = 12'd1;
        cfg_right     = 12'd640;
        cfg_bottom    = 12'd480;
        cfg_shift_x   = '0;
        cfg_shift_y   = '0;
        foreach (slot_state[i]) slot_state[i] = ST_DEAD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        dir_rows.push_back(tab_row(OP_APPEARED, 1, 1, 0, 1, 1, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 640, 480, 0, 1, 1, EV_MOVED, 65536, 65536));
        dir_rows.push_back(tab_row(OP_MOVED, 0, 1, 0, 1, 1, EV_LEFT, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 4095, 4095, 0, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 320, 240, 0, 0, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_VANISHED, 4095, 0, 0, 1, 1, EV_LEFT, 65536, 0));
        dir_rows.push_back(tab_row(OP_VANISHED, 320, 240, 0, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 100, 100, 15, 0, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_APPEARED, 4095, 100, 15, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_VANISHED, 100, 100, 15, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_UNUSED, 320, 240, 1, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 320, 240, 1, 0, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_APPEARED, 641, 240, 1, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 641, 240, 1, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_APPEARED, 2047, 2048, 2, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_APPEARED, 12'hAAA, 12'h555, 7, 1, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_APPEARED, 12'h155, 12'h0AA, 8, 0, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_MOVED, 639, 479, 3, 0, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_APPEARED, 2, 2, 3, 0, 0, EV_JOINED, 0, 0));
        dir_rows.push_back(tab_row(OP_VANISHED, 0, 0, 3, 1, 1, EV_LEFT, 0, 0));
        foreach (dir_rows[i])
            feed_word(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].slot,
                      dir_rows[i].typed, dir_rows[i].typed_has, dir_rows[i].ev);
        settle();

        set_area(0, 0, 4095, 4095, 0, 0);
        random_run(200);
        set_area(0, 0, 4095, 4095, -4096, 4095);
        random_run(50);
        set_area(0, 0, 4095, 4095, 4095, -4096);
        random_run(50);
        quiet_spell = 1'b1;
        set_area(300, 200, 300, 100, 0, 0);
        random_run(50);
        quiet_spell = 1'b0;
        set_area(100, 4094, 101, 4095, 0, 0);
        random_run(100);
        for (int k = 0; k < 4; k++) begin
            int l, t;
            l = $urandom_range(0, 3500);
            t = $urandom_range(0, 3500);
            quiet_spell = (k == 2);
            set_area(l, t, l + $urandom_range(1, 4095 - l), t + $urandom_range(1, 4095 - t),
                     int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300);
            random_run(130);
        end
        quiet_spell = 1'b0;
        cfg_write(CFG_SPARE_A, 13'($urandom));
        cfg_write(CFG_SPARE_B, 13'($urandom));
        random_run(100);
        set_area(1, 1, 640, 480, 0, 0);
        random_run(150);

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d event words over %0d area settings, %0d zone words checked.",
                 words_sent, settings_applied, results_checked);
        $display("Mismatches: %0d, words still awaited: %0d.", fail_count, pending_events.size());
        if (fail_count == 0 && pending_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
